// ===== rtl/png_header_encoder_top_assert.svh =====
// Assertion macros for the PNG header encoder.
// Used by the queue and back end modules; needs clk_i and rst_ni in scope.
`ifndef PNG_HEADER_ENCODER_TOP_ASSERT_SVH
`define PNG_HEADER_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define PHE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("png header encoder assertion failed");

`define PHE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("png header encoder sequencing assertion failed");

`else

`define PHE_ASSERT(lbl, prop)

`define PHE_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ===== rtl/png_hdr_pkg.sv =====
// Shared types, constants and functions of the PNG header encoder.
// No dependencies.
package png_hdr_pkg;

  localparam logic [31:0] ChunkType = 32'h49484452;
  localparam int unsigned NumBytes  = 21;
  localparam int unsigned LastIdx   = NumBytes - 1;
  localparam int unsigned CrcStart  = 17;
  localparam int unsigned IdxW      = $clog2(NumBytes);
  localparam logic [31:0] CrcPoly   = 32'hEDB88320;
  localparam logic [31:0] CrcInit   = 32'hFFFFFFFF;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] ColorGray      = 8'd0;
  localparam logic [7:0] ColorRgb       = 8'd2;
  localparam logic [7:0] ColorPalette   = 8'd3;
  localparam logic [7:0] ColorGrayAlpha = 8'd4;
  localparam logic [7:0] ColorRgba      = 8'd6;

  localparam int unsigned ErrWidth     = 0;
  localparam int unsigned ErrHeight    = 1;
  localparam int unsigned ErrDepth     = 2;
  localparam int unsigned ErrColor     = 3;
  localparam int unsigned ErrComp      = 4;
  localparam int unsigned ErrFilter    = 5;
  localparam int unsigned ErrInterlace = 6;
  localparam int unsigned ErrW         = 7;

  typedef struct packed {
    logic [31:0]     width;
    logic [31:0]     height;
    logic [7:0]      depth;
    logic [7:0]      color;
    logic [7:0]      comp;
    logic [7:0]      filt;
    logic [7:0]      ilace;
    logic [ErrW-1:0] err;
  } hdr_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } back_state_e;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [1:0] check_color(input logic [7:0] color, input logic [7:0] depth);
    // bit 1: color known, bit 0: depth allowed
    logic [1:0] r;
    case (color)
      ColorGray: begin
        r = {1'b1, depth inside {8'd1, 8'd2, 8'd4, 8'd8, 8'd16}};
      end
      ColorPalette: begin
        r = {1'b1, depth inside {8'd1, 8'd2, 8'd4, 8'd8}};
      end
      ColorRgb, ColorGrayAlpha, ColorRgba: begin
        r = {1'b1, depth inside {8'd8, 8'd16}};
      end
      default: begin
        r = 2'b01;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/png_hdr_front.sv =====
// Front end: accepts a header, checks it and builds the queued item.
// Depends on png_hdr_pkg.
module png_hdr_front (
  input  logic                  start,
  output logic                  busy,
  input  logic [31:0]           image_width_i,
  input  logic [31:0]           image_height_i,
  input  logic [7:0]            sample_depth_i,
  input  logic [7:0]            color_kind_i,
  input  logic [7:0]            compress_kind_i,
  input  logic [7:0]            filter_kind_i,
  input  logic [7:0]            interlace_kind_i,
  input  png_hdr_pkg::q_stat_t  q_stat_i,
  output logic                  push_o,
  output png_hdr_pkg::hdr_item_t item_o
);

  logic [1:0]                       color_chk;
  logic [png_hdr_pkg::ErrW-1:0]     err;

  assign color_chk = png_hdr_pkg::check_color(color_kind_i, sample_depth_i);

  always_comb begin
    err = '0;
    err[png_hdr_pkg::ErrWidth]     = (image_width_i == 32'd0);
    err[png_hdr_pkg::ErrHeight]    = (image_height_i == 32'd0);
    err[png_hdr_pkg::ErrDepth]     = !color_chk[0];
    err[png_hdr_pkg::ErrColor]     = !color_chk[1];
    err[png_hdr_pkg::ErrComp]      = (compress_kind_i != 8'd0);
    err[png_hdr_pkg::ErrFilter]    = (filter_kind_i != 8'd0);
    err[png_hdr_pkg::ErrInterlace] = (interlace_kind_i > 8'd1);
  end

  always_comb begin
    item_o.width  = image_width_i;
    item_o.height = image_height_i;
    item_o.depth  = sample_depth_i;
    item_o.color  = color_kind_i;
    item_o.comp   = compress_kind_i;
    item_o.filt   = filter_kind_i;
    item_o.ilace  = interlace_kind_i;
    item_o.err    = err;
  end

  assign busy   = q_stat_i.full;
  assign push_o = start && !q_stat_i.full;

endmodule

// ===== rtl/png_hdr_fifo.sv =====
// Short register queue of checked headers between front and back end.
// Depends on png_hdr_pkg and png_header_encoder_top_assert.svh.
`include "png_header_encoder_top_assert.svh"

module png_hdr_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  png_hdr_pkg::hdr_item_t wdata_i,
  input  logic                   pop_i,
  output png_hdr_pkg::hdr_item_t rdata_o,
  output png_hdr_pkg::q_stat_t   stat_o
);

  png_hdr_pkg::hdr_item_t               mem_q [png_hdr_pkg::QDepth];
  logic [png_hdr_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [png_hdr_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [png_hdr_pkg::QCntW-1:0]        cnt_q, cnt_d;

  function automatic logic [png_hdr_pkg::QPtrW-1:0] ptr_inc(
    input logic [png_hdr_pkg::QPtrW-1:0] p
  );
    if (p == png_hdr_pkg::QPtrW'(png_hdr_pkg::QDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign stat_o.full  = (cnt_q == png_hdr_pkg::QCntW'(png_hdr_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign rdata_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `PHE_ASSERT(a_no_overflow, !push_i || !stat_o.full)
  `PHE_ASSERT(a_no_underflow, !pop_i || !stat_o.empty)
  `PHE_ASSERT(a_cnt_bound, cnt_q <= png_hdr_pkg::QCntW'(png_hdr_pkg::QDepth))

endmodule

// ===== rtl/png_hdr_back.sv =====
// Back end: serializes one queued header per burst with a running CRC-32.
// Depends on png_hdr_pkg and png_header_encoder_top_assert.svh.
`include "png_header_encoder_top_assert.svh"

module png_hdr_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  png_hdr_pkg::hdr_item_t item_i,
  input  png_hdr_pkg::q_stat_t   q_stat_i,
  output logic                   pop_o,
  output logic                   valid_o,
  output logic [7:0]             out_byte_o,
  output logic                   last_byte_o,
  output logic [6:0]             error_mask_o
);

  png_hdr_pkg::back_state_e         state_q, state_d;
  png_hdr_pkg::hdr_item_t           item_q, item_d;
  logic [png_hdr_pkg::IdxW-1:0]     idx_q, idx_d;
  logic [png_hdr_pkg::IdxW-1:0]     sel;
  logic [31:0]                      crc_q, crc_d;
  logic [8*png_hdr_pkg::NumBytes-1:0] all_bytes;
  logic [7:0]                       cur_byte;
  logic                             last_now;
  logic                             load;
  logic                             valid_q, valid_d;
  logic [7:0]                       byte_q, byte_d;
  logic                             last_q, last_d;
  logic [png_hdr_pkg::ErrW-1:0]     mask_q, mask_d;

  assign all_bytes = {png_hdr_pkg::ChunkType, item_q.width, item_q.height, item_q.depth,
                      item_q.color, item_q.comp, item_q.filt, item_q.ilace, ~crc_q};
  assign sel       = png_hdr_pkg::IdxW'(png_hdr_pkg::LastIdx) - idx_q;
  assign cur_byte  = all_bytes[{sel, 3'b000} +: 8];
  assign last_now  = (state_q == png_hdr_pkg::ST_SEND) &&
                     ((item_q.err != '0) ||
                      (idx_q == png_hdr_pkg::IdxW'(png_hdr_pkg::LastIdx)));
  assign load      = ((state_q == png_hdr_pkg::ST_IDLE) || last_now) && !q_stat_i.empty;

  always_comb begin
    state_d = state_q;
    case (state_q)
      png_hdr_pkg::ST_IDLE: begin
        if (load) state_d = png_hdr_pkg::ST_SEND;
      end
      png_hdr_pkg::ST_SEND: begin
        if (last_now && !load) state_d = png_hdr_pkg::ST_IDLE;
      end
      default: begin
        state_d = png_hdr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_o   = load;
    valid_d = (state_q == png_hdr_pkg::ST_SEND);
    byte_d  = (item_q.err != '0) ? 8'd0 : cur_byte;
    last_d  = last_now;
    mask_d  = item_q.err;
    item_d  = load ? item_i : item_q;
    idx_d   = idx_q;
    crc_d   = crc_q;
    if (load) begin
      idx_d = '0;
      crc_d = png_hdr_pkg::CrcInit;
    end else if (state_q == png_hdr_pkg::ST_SEND) begin
      idx_d = idx_q + 1'b1;
      if (idx_q < png_hdr_pkg::IdxW'(png_hdr_pkg::CrcStart)) begin
        crc_d = png_hdr_pkg::crc_byte(crc_q, cur_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= png_hdr_pkg::ST_IDLE;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    crc_q  <= crc_d;
    byte_q <= byte_d;
    last_q <= last_d;
    mask_q <= mask_d;
  end

  assign valid_o      = valid_q;
  assign out_byte_o   = byte_q;
  assign last_byte_o  = last_q;
  assign error_mask_o = mask_q;

  `PHE_ASSERT(a_err_single, !valid_q || (mask_q == '0) || last_q)
  `PHE_ASSERT_NEXT(a_burst_contig, valid_q && !last_q, valid_q)
  `PHE_ASSERT_NEXT(a_idle_quiet, state_q == png_hdr_pkg::ST_IDLE, !valid_q)

endmodule

// ===== rtl/png_header_encoder_top.sv =====
// Top level of the PNG header encoder: front end, header queue, back end.
// Depends on png_hdr_pkg, png_hdr_front, png_hdr_fifo and png_hdr_back.
//
// Takes one IHDR description per start/!busy handshake and emits, one byte per cycle
// under valid_o, the chunk type, the 13 data bytes and the CRC-32, 21 bytes with
// last_byte_o on the final one; an invalid header gives a single byte with the error
// mask and last_byte_o set. A valid header holds the byte serializer for all its
// bytes, an invalid one for its one byte; the serializer folds the chunk type and
// data bytes into the CRC as it selects them, before registering them out. Two checked
// headers wait in a queue ahead of it, and busy is high only while that queue is full.
// Results cannot be held off: the receiver must take every byte as it appears.
module png_header_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] image_width_i,
  input  logic [31:0] image_height_i,
  input  logic [7:0]  sample_depth_i,
  input  logic [7:0]  color_kind_i,
  input  logic [7:0]  compress_kind_i,
  input  logic [7:0]  filter_kind_i,
  input  logic [7:0]  interlace_kind_i,
  output logic        valid_o,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o,
  output logic [6:0]  error_mask_o
);

  png_hdr_pkg::q_stat_t   q_stat;
  png_hdr_pkg::hdr_item_t push_item;
  png_hdr_pkg::hdr_item_t head_item;
  logic                   push;
  logic                   pop;

  png_hdr_front u_front (
    .start            (start),
    .busy             (busy),
    .image_width_i    (image_width_i),
    .image_height_i   (image_height_i),
    .sample_depth_i   (sample_depth_i),
    .color_kind_i     (color_kind_i),
    .compress_kind_i  (compress_kind_i),
    .filter_kind_i    (filter_kind_i),
    .interlace_kind_i (interlace_kind_i),
    .q_stat_i         (q_stat),
    .push_o           (push),
    .item_o           (push_item)
  );

  png_hdr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_item),
    .pop_i   (pop),
    .rdata_o (head_item),
    .stat_o  (q_stat)
  );

  png_hdr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (head_item),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .out_byte_o   (out_byte_o),
    .last_byte_o  (last_byte_o),
    .error_mask_o (error_mask_o)
  );

endmodule

// ===== tb/sv/png_header_encoder_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for png_header_encoder_top: IHDR items in, chunk bytes out.
// Depends on png_hdr_pkg and the png_header_encoder_top RTL.
module png_header_encoder_top_tb;

  localparam logic [7:0]  CompDeflate    = 8'd0;
  localparam logic [7:0]  FilterAdaptive = 8'd0;
  localparam logic [7:0]  IlaceNone      = 8'd0;
  localparam logic [7:0]  IlaceAdam7     = 8'd1;
  localparam int unsigned RandItems      = 104;
  localparam int unsigned CalmTail       = 30;
  localparam int unsigned CycleLimit     = 200000;

  typedef struct {
    logic [31:0] width;
    logic [31:0] height;
    logic [7:0]  depth;
    logic [7:0]  color;
    logic [7:0]  comp;
    logic [7:0]  filt;
    logic [7:0]  ilace;
  } ihdr_t;

  typedef struct {
    ihdr_t       hdr;
    int unsigned gap;
  } pending_t;

  typedef struct {
    logic [7:0]                  data;
    logic                        last;
    logic [png_hdr_pkg::ErrW-1:0] mask;
  } chunk_byte_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] image_width_i;
  logic [31:0] image_height_i;
  logic [7:0]  sample_depth_i;
  logic [7:0]  color_kind_i;
  logic [7:0]  compress_kind_i;
  logic [7:0]  filter_kind_i;
  logic [7:0]  interlace_kind_i;
  logic        valid_o;
  logic [7:0]  out_byte_o;
  logic        last_byte_o;
  logic [6:0]  error_mask_o;

  pending_t    hdr_pend_q[$];
  chunk_byte_t chunk_exp_q[$];
  pending_t    cur_pend;
  ihdr_t       cur_hdr;
  bit          in_flight;
  bit          took;
  int unsigned gap_left;
  int unsigned err_count;
  int unsigned cycles;

  png_header_encoder_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .image_width_i   (image_width_i),
    .image_height_i  (image_height_i),
    .sample_depth_i  (sample_depth_i),
    .color_kind_i    (color_kind_i),
    .compress_kind_i (compress_kind_i),
    .filter_kind_i   (filter_kind_i),
    .interlace_kind_i(interlace_kind_i),
    .valid_o         (valid_o),
    .out_byte_o      (out_byte_o),
    .last_byte_o     (last_byte_o),
    .error_mask_o    (error_mask_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic [png_hdr_pkg::ErrW-1:0] header_faults(ihdr_t h);
    logic [png_hdr_pkg::ErrW-1:0] m;
    logic known;
    logic depth_ok;
    m = '0;
    known = 1'b1;
    case (h.color)
      png_hdr_pkg::ColorGray: begin
        depth_ok = (h.depth == 8'd1) || (h.depth == 8'd2) || (h.depth == 8'd4) ||
                   (h.depth == 8'd8) || (h.depth == 8'd16);
      end
      png_hdr_pkg::ColorPalette: begin
        depth_ok = (h.depth == 8'd1) || (h.depth == 8'd2) || (h.depth == 8'd4) ||
                   (h.depth == 8'd8);
      end
      png_hdr_pkg::ColorRgb, png_hdr_pkg::ColorGrayAlpha, png_hdr_pkg::ColorRgba: begin
        depth_ok = (h.depth == 8'd8) || (h.depth == 8'd16);
      end
      default: begin
        known = 1'b0;
        depth_ok = 1'b1;
      end
    endcase
    m[png_hdr_pkg::ErrWidth]     = (h.width == 32'd0);
    m[png_hdr_pkg::ErrHeight]    = (h.height == 32'd0);
    m[png_hdr_pkg::ErrDepth]     = !depth_ok;
    m[png_hdr_pkg::ErrColor]     = !known;
    m[png_hdr_pkg::ErrComp]      = (h.comp != CompDeflate);
    m[png_hdr_pkg::ErrFilter]    = (h.filt != FilterAdaptive);
    m[png_hdr_pkg::ErrInterlace] = (h.ilace > IlaceAdam7);
    return m;
  endfunction

  function automatic logic [31:0] crc32_fold(logic [31:0] crc, logic [7:0] data);
    logic [31:0] acc;
    acc = crc ^ {24'd0, data};
    repeat (8) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ png_hdr_pkg::CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

  task automatic predict_chunk(ihdr_t h);
    logic [7:0]                   seq[png_hdr_pkg::NumBytes];
    logic [31:0]                  crc;
    logic [png_hdr_pkg::ErrW-1:0] m;
    chunk_byte_t                  e;
    m = header_faults(h);
    if (m != '0) begin
      e.data = 8'd0;
      e.last = 1'b1;
      e.mask = m;
      chunk_exp_q.push_back(e);
    end else begin
      for (int i = 0; i < 4; i++) begin
        seq[i]     = png_hdr_pkg::ChunkType[31 - 8 * i -: 8];
        seq[4 + i] = h.width[31 - 8 * i -: 8];
        seq[8 + i] = h.height[31 - 8 * i -: 8];
      end
      seq[12] = h.depth;
      seq[13] = h.color;
      seq[14] = h.comp;
      seq[15] = h.filt;
      seq[16] = h.ilace;
      crc = png_hdr_pkg::CrcInit;
      for (int i = 0; i < png_hdr_pkg::CrcStart; i++) begin
        crc = crc32_fold(crc, seq[i]);
      end
      crc = ~crc;
      for (int i = 0; i < 4; i++) begin
        seq[png_hdr_pkg::CrcStart + i] = crc[31 - 8 * i -: 8];
      end
      for (int i = 0; i < png_hdr_pkg::NumBytes; i++) begin
        e.data = seq[i];
        e.last = (i == png_hdr_pkg::LastIdx);
        e.mask = '0;
        chunk_exp_q.push_back(e);
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("%0t: %0s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  function automatic ihdr_t make_hdr(logic [31:0] w, logic [31:0] h, logic [7:0] d,
                                     logic [7:0] c, logic [7:0] cm, logic [7:0] f,
                                     logic [7:0] il);
    ihdr_t r;
    r.width  = w;
    r.height = h;
    r.depth  = d;
    r.color  = c;
    r.comp   = cm;
    r.filt   = f;
    r.ilace  = il;
    return r;
  endfunction

  function automatic logic [31:0] rand_dim();
    if ($urandom_range(0, 2) == 0) begin
      return $urandom();
    end
    return $urandom_range(1, 4096);
  endfunction

  function automatic ihdr_t rand_good_hdr();
    logic [7:0] colors[5];
    ihdr_t r;
    colors = '{png_hdr_pkg::ColorGray, png_hdr_pkg::ColorRgb, png_hdr_pkg::ColorPalette,
               png_hdr_pkg::ColorGrayAlpha, png_hdr_pkg::ColorRgba};
    r = make_hdr(rand_dim(), rand_dim(), 8'd8, colors[$urandom_range(0, 4)], CompDeflate,
                 FilterAdaptive, $urandom_range(0, 1) ? IlaceAdam7 : IlaceNone);
    if (r.width == 32'd0) r.width = 32'd1;
    if (r.height == 32'd0) r.height = 32'd1;
    do begin
      r.depth = 8'd1 << $urandom_range(0, 4);
    end while (header_faults(r) != '0);
    return r;
  endfunction

  always @(posedge clk_i) begin
    took = rst_ni && (start === 1'b1) && (busy === 1'b0);
    if (valid_o === 1'b1) begin
      if (chunk_exp_q.size() == 0) begin
        report_mismatch("byte with nothing expected", 32'(out_byte_o), 32'd0);
      end else begin
        chunk_byte_t e;
        e = chunk_exp_q.pop_front();
        if (out_byte_o !== e.data) begin
          report_mismatch("out_byte", 32'(out_byte_o), 32'(e.data));
        end
        if (last_byte_o !== e.last) begin
          report_mismatch("last_byte", 32'(last_byte_o), 32'(e.last));
        end
        if (error_mask_o !== e.mask) begin
          report_mismatch("error_mask", 32'(error_mask_o), 32'(e.mask));
        end
      end
    end
    if (took) begin
      predict_chunk(cur_hdr);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_flight && took) begin
        in_flight = 1'b0;
        gap_left = (hdr_pend_q.size() > 0) ? hdr_pend_q[0].gap : 0;
      end
      if (!in_flight) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (hdr_pend_q.size() > 0) begin
          cur_pend = hdr_pend_q.pop_front();
          cur_hdr = cur_pend.hdr;
          in_flight = 1'b1;
          image_width_i    <= cur_hdr.width;
          image_height_i   <= cur_hdr.height;
          sample_depth_i   <= cur_hdr.depth;
          color_kind_i     <= cur_hdr.color;
          compress_kind_i  <= cur_hdr.comp;
          filter_kind_i    <= cur_hdr.filt;
          interlace_kind_i <= cur_hdr.ilace;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [7:0] colors[5];
    ihdr_t      h;
    int unsigned k;
    bit         idle_on;

    rst_ni           = 1'b0;
    start            = 1'b0;
    image_width_i    = '0;
    image_height_i   = '0;
    sample_depth_i   = '0;
    color_kind_i     = '0;
    compress_kind_i  = '0;
    filter_kind_i    = '0;
    interlace_kind_i = '0;
    in_flight        = 1'b0;
    took             = 1'b0;
    gap_left         = 0;
    err_count        = 0;
    cycles           = 0;

    // every legal color and depth pair, dimension extremes on the first two
    colors = '{png_hdr_pkg::ColorGray, png_hdr_pkg::ColorRgb, png_hdr_pkg::ColorPalette,
               png_hdr_pkg::ColorGrayAlpha, png_hdr_pkg::ColorRgba};
    k = 0;
    foreach (colors[c]) begin
      for (int s = 0; s < 5; s++) begin
        h = make_hdr(32'd1, 32'd1, 8'd1 << s, colors[c], CompDeflate, FilterAdaptive,
                     (k % 2) ? IlaceAdam7 : IlaceNone);
        if (k == 1) begin
          h.width  = 32'hFFFF_FFFF;
          h.height = 32'hFFFF_FFFF;
        end else if (k > 1) begin
          h.width  = rand_dim() | 32'd1;
          h.height = rand_dim() | 32'd1;
        end
        if (header_faults(h) == '0) begin
          hdr_pend_q.push_back('{hdr: h, gap: 0});
          k++;
        end
      end
    end

    // single faults, unknown color with odd depth, and everything wrong at once
    hdr_pend_q.push_back('{hdr: make_hdr(32'd0, 32'd5, 8'd8, png_hdr_pkg::ColorRgb,
                                         CompDeflate, FilterAdaptive, IlaceNone), gap: 0});
    hdr_pend_q.push_back('{hdr: make_hdr(32'd5, 32'd0, 8'd8, png_hdr_pkg::ColorRgb,
                                         CompDeflate, FilterAdaptive, IlaceNone), gap: 0});
    hdr_pend_q.push_back('{hdr: make_hdr(32'd7, 32'd7, 8'd3, png_hdr_pkg::ColorGray,
                                         CompDeflate, FilterAdaptive, IlaceNone), gap: 0});
    hdr_pend_q.push_back('{hdr: make_hdr(32'd7, 32'd7, 8'd16, png_hdr_pkg::ColorPalette,
                                         CompDeflate, FilterAdaptive, IlaceNone), gap: 0});
    hdr_pend_q.push_back('{hdr: make_hdr(32'd7, 32'd7, 8'd4, png_hdr_pkg::ColorRgb,
                                         CompDeflate, FilterAdaptive, IlaceNone), gap: 0});
    hdr_pend_q.push_back('{hdr: make_hdr(32'd7, 32'd7, 8'd8, 8'd1, CompDeflate,
                                         FilterAdaptive, IlaceNone), gap: 0});
    hdr_pend_q.push_back('{hdr: make_hdr(32'd7, 32'd7, 8'd3, 8'hFF, CompDeflate,
                                         FilterAdaptive, IlaceNone), gap: 0});
    hdr_pend_q.push_back('{hdr: make_hdr(32'd7, 32'd7, 8'd8, png_hdr_pkg::ColorGray, 8'hFF,
                                         FilterAdaptive, IlaceNone), gap: 0});
    hdr_pend_q.push_back('{hdr: make_hdr(32'd7, 32'd7, 8'd8, png_hdr_pkg::ColorGray,
                                         CompDeflate, 8'h80, IlaceNone), gap: 0});
    hdr_pend_q.push_back('{hdr: make_hdr(32'd7, 32'd7, 8'd8, png_hdr_pkg::ColorGray,
                                         CompDeflate, FilterAdaptive, 8'd2), gap: 0});
    hdr_pend_q.push_back('{hdr: make_hdr(32'd0, 32'd0, 8'hFF, 8'd7, 8'hFF, 8'hFF, 8'hFF),
                           gap: 0});

    idle_on = 1'b0;
    for (int i = 0; i < RandItems; i++) begin
      int unsigned g;
      int unsigned pick;
      if (i % 8 == 0) idle_on = $urandom_range(0, 1);
      g = 0;
      if (idle_on && i < RandItems - CalmTail && $urandom_range(0, 2) != 0) begin
        g = $urandom_range(1, 18);
      end
      pick = $urandom_range(0, 9);
      h = rand_good_hdr();
      if (pick == 9) begin
        h = make_hdr($urandom(), $urandom(), 8'($urandom()), 8'($urandom()),
                     8'($urandom()), 8'($urandom()), 8'($urandom()));
      end else if (pick >= 7) begin
        case ($urandom_range(0, 6))
          0: h.width  = ($urandom_range(0, 1)) ? 32'd0 : $urandom();
          1: h.height = ($urandom_range(0, 1)) ? 32'd0 : $urandom();
          2: h.depth  = 8'($urandom());
          3: h.color  = 8'($urandom());
          4: h.comp   = 8'($urandom());
          5: h.filt   = 8'($urandom());
          default: h.ilace = 8'($urandom());
        endcase
      end
      hdr_pend_q.push_back('{hdr: h, gap: g});
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (hdr_pend_q.size() > 0 || in_flight) @(posedge clk_i);
    while (chunk_exp_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
